### src/accm_pkg.sv
// accm_pkg: shared constants, widths and opcode type of the accumulator machine step block
// no dependencies; imported by accumulator_machine_step and tb_accumulator_machine_step
package accm_pkg;

    localparam int DATA_WORDS    = 128;
    localparam int PROGRAM_WORDS = 128;

    localparam int ADDR_W = $clog2(DATA_WORDS);
    localparam int SLOT_W = ADDR_W + 1;
    localparam int PC_W   = 8;
    localparam int WORD_W = 32;
    localparam int OP_W   = 4;

    localparam int IN_FIELDS_W  = OP_W + WORD_W + ADDR_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = PC_W + 1 + WORD_W + WORD_W + 1 + 1 + ADDR_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [PC_W-1:0]   LENGTH_RESET = PC_W'(128);
    localparam logic [WORD_W-1:0] POS_FIX      = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_FIX      = 32'h8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_HLT = 4'd0,
        OP_DEC = 4'd1,
        OP_LDI = 4'd2,
        OP_XCH = 4'd3,
        OP_ADD = 4'd4,
        OP_STR = 4'd5,
        OP_JMP = 4'd6,
        OP_JZS = 4'd7,
        OP_JVS = 4'd8,
        OP_LDA = 4'd9,
        OP_LDB = 4'd10
    } op_t;

endpackage

### src/accm_ram.sv
// accm_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
module accm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/accumulator_machine_step.sv
// accumulator_machine_step: executes one fetched instruction of an accumulator machine per transfer
// depends on accm_pkg and accm_ram (data store)
//
// usage:
//   s_axis carries one instruction per transfer; m_axis returns one result per instruction
//   showing pc, halt, A, B, sticky flags and the DEC allocation after that instruction.
//   cfg writes program_length (8 bit); write it only while the block is idle.
// data path: the data store read and the execute stage are registered on the input transfer,
//   then the execute result is registered into the output register.
// throughput: one instruction per cycle while m_axis is not stalled; the store read is issued on
//   the input transfer and a write from the instruction ahead is forwarded, so dependent
//   instructions follow back to back.
// reset: A, B, flags, pc, allocation pointer and halt clear; program_length becomes 128;
//   the data store reads as zero through per-word valid bits, so no clearing pass.
// stall: while m_axis_tready is low the result holds, one more instruction waits in the
//   execute stage, and s_axis_tready drops until the result is taken.
module accumulator_machine_step (
    input  logic                           clk,
    input  logic                           rst_n,
    // fields from bit 0: req_type[3:0], immediate[35:4], address[42:36], zero pad
    input  logic [accm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // fields from bit 0: next_pc[7:0], halted[8], reg_a_out[40:9], reg_b_out[72:41],
    // zero_out[73], overflow_out[74], alloc_slot[81:75], alloc_ok[82], zero pad
    output logic [accm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [accm_pkg::PC_W-1:0]      cfg_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready
);

    import accm_pkg::*;

    // input unpack
    logic [OP_W-1:0]   in_op;
    logic [WORD_W-1:0] in_imm;
    logic [ADDR_W-1:0] in_addr;
    logic              in_fire;

    assign in_op   = s_axis_tdata[OP_W-1:0];
    assign in_imm  = s_axis_tdata[OP_W+WORD_W-1:OP_W];
    assign in_addr = s_axis_tdata[OP_W+WORD_W+ADDR_W-1:OP_W+WORD_W];

    // architectural state
    logic [PC_W-1:0]       length_reg;
    logic [WORD_W-1:0]     a_reg, a_next;
    logic [WORD_W-1:0]     b_reg, b_next;
    logic                  z_reg, z_next;
    logic                  v_reg, v_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [SLOT_W-1:0]     nfs_reg, nfs_next;
    logic                  halt_reg, halt_next;
    logic [DATA_WORDS-1:0] valid_reg;

    // execute stage
    logic              ex_valid_reg;
    logic [OP_W-1:0]   ex_op_reg;
    logic [WORD_W-1:0] ex_imm_reg;
    logic [ADDR_W-1:0] ex_addr_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              rd_valid_reg;
    logic              ex_fire;

    // output register
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic [OUT_TDATA_W-1:0]  out_data_next;

    // data store port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;
    logic [WORD_W-1:0] rd_data;

    // execute combinational
    logic [PC_W-1:0]   limit;
    logic              run;
    logic [WORD_W:0]   sum;
    logic [ADDR_W-1:0] slot;
    logic              ok;

    assign ex_fire       = ex_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !ex_valid_reg || ex_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    accm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DATA_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (mem_rdata)
    );

    // a write from the instruction ahead lands at the same edge as this read
    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? mem_rdata    : '0;

    assign limit = (length_reg > PC_W'(PROGRAM_WORDS)) ? PC_W'(PROGRAM_WORDS) : length_reg;
    assign run   = !halt_reg && (pc_reg < limit);
    assign sum   = {a_reg[WORD_W-1], a_reg} + {b_reg[WORD_W-1], b_reg};

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        z_next    = z_reg;
        v_next    = v_reg;
        pc_next   = pc_reg;
        nfs_next  = nfs_reg;
        halt_next = halt_reg;
        slot      = '0;
        ok        = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ex_addr_reg;
        mem_wdata = a_reg;
        if (run)
        begin
            pc_next = pc_reg + PC_W'(1);
            unique case (op_t'(ex_op_reg))
                OP_HLT:
                begin
                    halt_next = 1'b1;
                    pc_next   = pc_reg;
                end
                OP_DEC:
                begin
                    if (nfs_reg < SLOT_W'(DATA_WORDS))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = nfs_reg[ADDR_W-1:0];
                        mem_wdata = '0;
                        slot      = nfs_reg[ADDR_W-1:0];
                        ok        = 1'b1;
                        nfs_next  = nfs_reg + SLOT_W'(1);
                    end
                end
                OP_LDI: a_next = ex_imm_reg;
                OP_XCH:
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                OP_ADD:
                begin
                    if (sum == '0)
                    begin
                        z_next = 1'b1;
                    end
                    // above max: subtract 2^31-1; below min: add 2^31
                    if (!sum[WORD_W] && sum[WORD_W-1])
                    begin
                        a_next = sum[WORD_W-1:0] - POS_FIX;
                        v_next = 1'b1;
                    end
                    else if (sum[WORD_W] && !sum[WORD_W-1])
                    begin
                        a_next = sum[WORD_W-1:0] + NEG_FIX;
                        v_next = 1'b1;
                    end
                    else
                    begin
                        a_next = sum[WORD_W-1:0];
                    end
                end
                OP_STR: mem_we = 1'b1;
                OP_JMP: pc_next = PC_W'(ex_addr_reg);
                OP_JZS:
                begin
                    if (z_reg)
                    begin
                        pc_next = PC_W'(ex_addr_reg);
                    end
                end
                OP_JVS:
                begin
                    if (v_reg)
                    begin
                        pc_next = PC_W'(ex_addr_reg);
                    end
                end
                OP_LDA: a_next = rd_data;
                OP_LDB: b_next = rd_data;
                default: ;
            endcase
            if (pc_next >= limit)
            begin
                halt_next = 1'b1;
            end
        end
        else
        begin
            halt_next = 1'b1;
        end
        mem_we = mem_we && ex_fire;
        out_data_next = {{OUT_PAD_W{1'b0}}, ok, slot, v_next, z_next,
                         b_next, a_next, halt_next, pc_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= LENGTH_RESET;
            a_reg         <= '0;
            b_reg         <= '0;
            z_reg         <= 1'b0;
            v_reg         <= 1'b0;
            pc_reg        <= '0;
            nfs_reg       <= '0;
            halt_reg      <= 1'b0;
            valid_reg     <= '0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                length_reg <= cfg_data;
            end
            if (in_fire)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire)
            begin
                a_reg         <= a_next;
                b_reg         <= b_next;
                z_reg         <= z_next;
                v_reg         <= v_next;
                pc_reg        <= pc_next;
                nfs_reg       <= nfs_next;
                halt_reg      <= halt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ex_op_reg    <= in_op;
            ex_imm_reg   <= in_imm;
            ex_addr_reg  <= in_addr;
            fwd_hit_reg  <= mem_we && (mem_waddr == in_addr);
            fwd_data_reg <= mem_wdata;
            rd_valid_reg <= valid_reg[in_addr];
        end
        if (ex_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;

    // allocation pointer never runs past the store
    a_nfs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfs_reg <= SLOT_W'(DATA_WORDS))
        else $error("allocation pointer beyond data store");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt state cleared");

    // every store write marks its word as written
    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(mem_waddr)])
        else $error("written word not marked valid");

    // input is refused only while an instruction waits behind a stalled result
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (ex_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input refused without a stall");

endmodule

### bench/tb_accumulator_machine_step.sv
// tb_accumulator_machine_step: self-checking bench for the accumulator machine step block
// depends on accm_pkg and accumulator_machine_step; keeps its own copy of the machine state,
// predicts each result and checks the m_axis stream against it in order
module tb_accumulator_machine_step;
    timeunit 1ns;
    timeprecision 1ps;
    import accm_pkg::*;

    localparam int     CLK_HALF    = 6;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     REPORT_MAX  = 10;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] imm;
        logic [OP_W-1:0]   op;
    } instr_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] slot;
        logic              ovf;
        logic              zero;
        logic [WORD_W-1:0] reg_b;
        logic [WORD_W-1:0] reg_a;
        logic              halted;
        logic [PC_W-1:0]   pc;
    } result_t;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [PC_W-1:0]        cfg_data;
    logic                   cfg_valid;
    logic                   cfg_ready;

    // machine state as the bench expects it
    logic [WORD_W-1:0] mach_a = '0;
    logic [WORD_W-1:0] mach_b = '0;
    logic              mach_zero = 1'b0;
    logic              mach_ovf = 1'b0;
    logic              mach_halted = 1'b0;
    logic [PC_W-1:0]   mach_pc = '0;
    logic [PC_W-1:0]   mach_length = LENGTH_RESET;
    logic [WORD_W-1:0] mach_store [DATA_WORDS];
    int                mach_free = 0;

    result_t expected_q [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      hold_cycles = 0;
    bit      send_no_idle = 1'b0;
    bit      recv_no_idle = 1'b0;

    accumulator_machine_step DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_data     (cfg_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic int pc_limit();
        return (int'(mach_length) > PROGRAM_WORDS) ? PROGRAM_WORDS : int'(mach_length);
    endfunction

    // one instruction on the expected machine, returns the state after it
    function automatic result_t execute_instr(input instr_t ins);
        result_t           r;
        logic [PC_W-1:0]   npc;
        logic [WORD_W-1:0] tmp;
        longint            sum;
        r = '0;
        if (!mach_halted && int'(mach_pc) < pc_limit())
        begin
            npc = mach_pc + PC_W'(1);
            case (ins.op)
                OP_HLT:
                begin
                    mach_halted = 1'b1;
                    npc = mach_pc;
                end
                OP_DEC:
                    if (mach_free < DATA_WORDS)
                    begin
                        mach_store[ADDR_W'(mach_free)] = '0;
                        r.slot = ADDR_W'(mach_free);
                        r.ok = 1'b1;
                        mach_free++;
                    end
                OP_LDI: mach_a = ins.imm;
                OP_XCH:
                begin
                    tmp = mach_a;
                    mach_a = mach_b;
                    mach_b = tmp;
                end
                OP_ADD:
                begin
                    sum = longint'($signed(mach_a)) + longint'($signed(mach_b));
                    if (sum == 0)
                        mach_zero = 1'b1;
                    // out-of-range sums take the block's own correction, not a wrap
                    if (sum > WORD_MAX)
                    begin
                        sum = sum - WORD_MAX;
                        mach_ovf = 1'b1;
                    end
                    else if (sum < WORD_MIN)
                    begin
                        sum = sum - WORD_MIN;
                        mach_ovf = 1'b1;
                    end
                    mach_a = sum[WORD_W-1:0];
                end
                OP_STR: mach_store[ins.addr] = mach_a;
                OP_JMP: npc = PC_W'(ins.addr);
                OP_JZS:
                    if (mach_zero)
                        npc = PC_W'(ins.addr);
                OP_JVS:
                    if (mach_ovf)
                        npc = PC_W'(ins.addr);
                OP_LDA: mach_a = mach_store[ins.addr];
                OP_LDB: mach_b = mach_store[ins.addr];
                default: ;
            endcase
            mach_pc = npc;
            if (int'(mach_pc) >= pc_limit())
                mach_halted = 1'b1;
        end
        else
            mach_halted = 1'b1;
        r.pc = mach_pc;
        r.halted = mach_halted;
        r.reg_a = mach_a;
        r.reg_b = mach_b;
        r.zero = mach_zero;
        r.ovf = mach_ovf;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return POS_FIX;
            1: return NEG_FIX;
            2: return {WORD_W{1'b1}};
            3: return WORD_W'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    // random instruction that keeps the machine running: pc never leaves the program
    function automatic instr_t random_live_instr();
        instr_t ins;
        int     lim;
        bit     jumps;
        lim = pc_limit();
        ins.imm = random_word();
        // a few hot slots so stores and loads meet each other
        ins.addr = ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom_range(0, 7))
                                                : ADDR_W'($urandom());
        if ($urandom_range(0, 19) == 0)
            ins.op = OP_W'($urandom_range(int'(OP_LDB) + 1, (1 << OP_W) - 1));
        else
            ins.op = OP_W'($urandom_range(int'(OP_DEC), int'(OP_LDB)));
        if (ins.op inside {OP_JMP, OP_JZS, OP_JVS})
            ins.addr = ADDR_W'($urandom_range(0, lim - 1));
        jumps = (ins.op == OP_JMP) || (ins.op == OP_JZS && mach_zero)
                || (ins.op == OP_JVS && mach_ovf);
        if (!jumps && int'(mach_pc) + 1 >= lim)
        begin
            ins.op = OP_JMP;
            ins.addr = ADDR_W'($urandom_range(0, lim - 1));
        end
        return ins;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("pc=%0d halt=%0b a=%h b=%h z=%0b v=%0b slot=%0d ok=%0b",
                         r.pc, r.halted, r.reg_a, r.reg_b, r.zero, r.ovf, r.slot, r.ok);
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    task automatic send_instr(input instr_t ins);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= IN_TDATA_W'(ins);
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        expected_q.push_back(execute_instr(ins));
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm,
                           input logic [ADDR_W-1:0] addr);
        instr_t ins;
        ins.op = op;
        ins.imm = imm;
        ins.addr = addr;
        send_instr(ins);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_length(input logic [PC_W-1:0] len);
        wait_idle();
        @(negedge clk);
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        mach_length = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // park pc at 0 first so the new length does not end the program
    task automatic set_length(input logic [PC_W-1:0] len);
        if (mach_pc >= len)
            send_op(OP_JMP, random_word(), '0);
        write_length(len);
    endtask

    task automatic test_directed();
        send_no_idle = 1'b1;
        recv_no_idle = 1'b1;
        send_op(OP_LDI, WORD_W'(3), '0);
        send_op(OP_XCH, '0, '0);
        send_op(OP_LDI, WORD_W'(4), '0);
        send_op(OP_ADD, '0, '0);
        // flags still clear: conditional jumps fall through
        send_op(OP_JZS, '0, ADDR_W'(90));
        send_op(OP_JVS, '0, ADDR_W'(127));
        // positive overflow
        send_op(OP_LDI, POS_FIX, '0);
        send_op(OP_XCH, '0, '0);
        send_op(OP_LDI, POS_FIX, '0);
        send_op(OP_ADD, '0, '0);
        // negative overflow
        send_op(OP_LDI, NEG_FIX, '0);
        send_op(OP_XCH, '0, '0);
        send_op(OP_LDI, NEG_FIX, '0);
        send_op(OP_ADD, '0, '0);
        // exact zero sum
        send_op(OP_LDI, WORD_W'(5), '0);
        send_op(OP_XCH, '0, '0);
        send_op(OP_LDI, WORD_W'(-5), '0);
        send_op(OP_ADD, '0, '0);
        send_op(OP_JZS, '0, ADDR_W'(100));
        send_op(OP_JVS, '0, ADDR_W'(120));
        // back-to-back store and load of the same slot
        send_op(OP_STR, '0, ADDR_W'(127));
        send_op(OP_LDA, '0, ADDR_W'(127));
        send_op(OP_LDB, '0, '0);
        send_op(OP_STR, '0, '0);
        send_op(OP_LDA, '0, '0);
        send_op(OP_DEC, '0, '0);
        send_op(OP_W'((1 << OP_W) - 1), {WORD_W{1'b1}}, {ADDR_W{1'b1}});
        send_op(OP_JMP, '0, '0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                {recv_no_idle, send_no_idle} = 2'($urandom_range(0, 3));
            send_instr(random_live_instr());
        end
    endtask

    task automatic test_backpressure();
        send_no_idle = 1'b1;
        hold_cycles = 200;
        for (int i = 0; i < 40; i++)
            send_instr(random_live_instr());
    endtask

    task automatic test_store_full();
        int extra;
        extra = 0;
        while (extra < 4)
        begin
            if (mach_free == DATA_WORDS)
                extra++;
            if (int'(mach_pc) + 1 >= pc_limit())
                send_op(OP_JMP, random_word(), '0);
            else
                send_op(OP_DEC, random_word(), ADDR_W'($urandom()));
        end
    endtask

    // halt is permanent without reset, so one way of stopping is picked per run
    task automatic test_halt();
        int lim;
        lim = pc_limit();
        case ($urandom_range(0, 2))
            0: send_op(OP_HLT, random_word(), ADDR_W'($urandom()));
            1:
            begin
                send_op(OP_JMP, '0, ADDR_W'(lim - 1));
                send_op(OP_LDI, random_word(), '0);
            end
            default:
            begin
                // length lowered to pc or below: the next step executes nothing
                send_op(OP_JMP, '0, ADDR_W'($urandom_range(1, lim - 1)));
                write_length(PC_W'($urandom_range(1, int'(mach_pc))));
                send_op(OP_LDA, '0, '0);
            end
        endcase
        for (int i = 0; i < 12; i++)
            send_op(OP_W'($urandom_range(0, (1 << OP_W) - 1)), random_word(),
                    ADDR_W'($urandom()));
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = recv_no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
            if (expected_q.size() == 0)
                note_failure($sformatf("unexpected result transfer: %s", fmt_result(got)));
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                    note_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                           fmt_result(want), fmt_result(got)));
            end
        end
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count > CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        foreach (mach_store[i])
            mach_store[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        set_length(PC_W'(127));
        test_random(400);
        set_length(PC_W'(1));
        test_random(15);
        set_length(PC_W'(2));
        test_random(20);
        set_length(PC_W'($urandom_range(3, 126)));
        test_random(300);
        test_backpressure();
        test_store_full();
        set_length(LENGTH_RESET);
        test_random(350);
        test_halt();

        wait_idle();
        repeat (4) @(negedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
